>>> hdl/shc_pkg.sv
package shc_pkg;

	localparam int WORD_W = 40;
	localparam int DATA_W = 30;
	localparam int SYN_W  = 6;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [SYN_W-1:0]  syn_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_CORR   = 2'd1,
		ST_UNCORR = 2'd2
	} status_t;

	localparam logic KIND_ENC = 1'b0;
	localparam logic KIND_DEC = 1'b1;

	// positions 3, 5 and 6 are reserved
	localparam word_t RESERVED_CLEAR = 40'hE9_FFFF_FFFF;

	// word bits whose code position (1..39) has bit k set
	function automatic word_t cover_mask(input int k);
		word_t m;
		m = '0;
		for (int p = 1; p < WORD_W; p++) begin
			if (((p >> k) & 1) != 0) begin
				m[WORD_W-1-p] = 1'b1;
			end
		end
		return m;
	endfunction

	function automatic word_t place_data(input data_t d);
		word_t w;
		w = '0;
		w[6:0]   = d[6:0];
		w[22:8]  = d[21:7];
		w[30:24] = d[28:22];
		w[32]    = d[29];
		return w;
	endfunction

	function automatic data_t take_data(input word_t w);
		data_t d;
		d[6:0]   = w[6:0];
		d[21:7]  = w[22:8];
		d[28:22] = w[30:24];
		d[29]    = w[32];
		return d;
	endfunction

endpackage

>>> hdl/shc_enc.sv
module shc_enc
	import shc_pkg::*;
(
	input  data_t data,
	output word_t codeword
);

	word_t placed;
	word_t with_par;
	syn_t  par;

	assign placed = place_data(data);

	// parity positions are never covered by another parity group
	always_comb begin
		with_par = placed;
		for (int k = 0; k < SYN_W; k++) begin
			par[k] = ^(placed & cover_mask(k));
			with_par[WORD_W-1-(1 << k)] = par[k];
		end
	end

	always_comb begin
		codeword = with_par;
		codeword[WORD_W-1] = ^with_par;
	end

endmodule

>>> hdl/shc_dec.sv
module shc_dec
	import shc_pkg::*;
(
	input  word_t   codeword_rx,
	output word_t   codeword_fix,
	output data_t   data,
	output status_t status
);

	word_t r;
	word_t flip;
	syn_t  syn;
	logic  overall;

	assign r       = codeword_rx & RESERVED_CLEAR;
	assign overall = ^r;

	always_comb begin
		for (int k = 0; k < SYN_W; k++) begin
			syn[k] = ^(r & cover_mask(k));
		end
	end

	// syndrome of 40 or more matches no bit
	always_comb begin
		for (int i = 0; i < WORD_W; i++) begin
			flip[i] = (syn == SYN_W'(WORD_W - 1 - i));
		end
	end

	always_comb begin
		codeword_fix = r;
		status       = ST_OK;
		if (syn != '0) begin
			if (!overall) begin
				status = ST_UNCORR;
			end else begin
				status       = ST_CORR;
				codeword_fix = r ^ flip;
			end
		end
	end

	assign data = take_data(codeword_fix);

endmodule

>>> hdl/secded_hamming_codec_30bit_core.sv
// SECDED codec for a 40-bit word carrying 30 data bits.
// Input channel: a beat is taken on a rising edge with start high and busy
// low. kind selects encode of data_in or check/correct of codeword_in.
// busy stays low: a new beat may be issued every cycle.
// Output channel: done is high for one cycle with codeword_out, data_out and
// status valid in that cycle. There is no backpressure; the receiver must
// take each beat in the cycle it is shown.
// Path: an input register, one level of parity trees, a result register;
// done is registered alongside the results.
// Throughput: one beat per cycle, set by the single register-to-register
// pass through the parity trees.
// status: 0 clean, 1 single error corrected, 2 uncorrectable double error.
// Reset clears the valid pipeline, so no done is raised for anything in
// flight; result payload is not reset.
module secded_hamming_codec_30bit_core
	import shc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [29:0] data_in,
	input  logic [39:0] codeword_in,
	output logic        done,
	output logic [39:0] codeword_out,
	output logic [29:0] data_out,
	output logic [1:0]  status
);

	logic    valid_s1;
	logic    kind_s1;
	data_t   data_s1;
	word_t   cw_s1;

	word_t   enc_cw;
	word_t   dec_cw;
	data_t   dec_data;
	status_t dec_status;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1 <= kind;
			data_s1 <= data_in;
			cw_s1   <= codeword_in;
		end
	end

	shc_enc u_enc (
		.data     (data_s1),
		.codeword (enc_cw)
	);

	shc_dec u_dec (
		.codeword_rx  (cw_s1),
		.codeword_fix (dec_cw),
		.data         (dec_data),
		.status       (dec_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (kind_s1 == KIND_ENC) begin
				codeword_out <= enc_cw;
				data_out     <= data_s1;
				status       <= ST_OK;
			end else begin
				codeword_out <= dec_cw;
				data_out     <= dec_data;
				status       <= dec_status;
			end
		end
	end

	a_beat_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("accepted beat did not produce done");

	a_enc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == KIND_ENC |=> ##1 status == ST_OK)
		else $error("encode reported an error status");

	a_enc_parity: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == KIND_ENC |=> ##1
		(^codeword_out == 1'b0) && ((codeword_out & ~RESERVED_CLEAR) == '0))
		else $error("encoded word has odd parity or reserved bits set");

	a_enc_echo: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == KIND_ENC |-> ##2 data_out == $past(data_in, 2))
		else $error("encode did not echo data_in");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import shc_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PRINT_LIMIT = 50;

	typedef struct packed {
		word_t   cw;
		data_t   data;
		status_t st;
	} codec_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [29:0] data_in;
	logic [39:0] codeword_in;
	logic        done;
	logic [39:0] codeword_out;
	logic [29:0] data_out;
	logic [1:0]  status;

	codec_result_t pending_results[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit steady_flow = 1'b0;

	secded_hamming_codec_30bit_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.data_in      (data_in),
		.codeword_in  (codeword_in),
		.done         (done),
		.codeword_out (codeword_out),
		.data_out     (data_out),
		.status       (status)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// word bits 0..32 carry data except those at parity positions 32, 16 and 8
	function automatic logic carries_data(input int b);
		return (b <= 32) && (b != 7) && (b != 23) && (b != 31);
	endfunction

	function automatic word_t spread_data(input data_t d);
		word_t w;
		int j;
		w = '0;
		j = 0;
		for (int b = 0; b < WORD_W; b++) begin
			if (carries_data(b)) begin
				w[b] = d[j];
				j++;
			end
		end
		return w;
	endfunction

	function automatic data_t gather_data(input word_t w);
		data_t d;
		int j;
		d = '0;
		j = 0;
		for (int b = 0; b < WORD_W; b++) begin
			if (carries_data(b)) begin
				d[j] = w[b];
				j++;
			end
		end
		return d;
	endfunction

	// xor of the code positions of all set bits, overall parity bit excluded
	function automatic syn_t position_xor(input word_t w);
		syn_t s;
		s = '0;
		for (int p = 1; p < WORD_W; p++) begin
			if (w[WORD_W-1-p]) begin
				s ^= syn_t'(p);
			end
		end
		return s;
	endfunction

	function automatic word_t flip_at(input word_t w, input int p);
		return w ^ (word_t'(1) << (WORD_W-1-p));
	endfunction

	function automatic word_t encode_word(input data_t d);
		word_t w;
		syn_t s;
		w = spread_data(d);
		s = position_xor(w);
		for (int k = 0; k < SYN_W; k++) begin
			if (s[k]) begin
				w[WORD_W-1-(1 << k)] = 1'b1;
			end
		end
		w[WORD_W-1] = ^w;
		return w;
	endfunction

	function automatic codec_result_t codec_predict(input logic k, input data_t d,
	                                                input word_t c);
		codec_result_t res;
		word_t r;
		syn_t s;
		res.st = ST_OK;
		if (k == KIND_ENC) begin
			res.cw = encode_word(d);
			res.data = d;
		end else begin
			r = c & RESERVED_CLEAR;
			s = position_xor(r);
			if (s != '0) begin
				if (^r == 1'b0) begin
					res.st = ST_UNCORR;
				end else begin
					res.st = ST_CORR;
					if (s < WORD_W) begin
						r = flip_at(r, int'(s));
					end
				end
			end
			res.cw = r;
			res.data = gather_data(r);
		end
		return res;
	endfunction

	function automatic word_t rand_word();
		logic [31:0] lo;
		logic [7:0]  hi;
		lo = $urandom();
		hi = 8'($urandom_range(0, 255));
		return {hi, lo};
	endfunction

	function automatic data_t rand_data();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return '1;
		end
		return data_t'($urandom());
	endfunction

	task automatic report_mismatch(input string field, input logic [39:0] got,
	                               input logic [39:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("mismatch on %s at %0t: got %h, want %h", field, $time, got, want);
		end
	endtask

	// one beat in, expectation queued at the edge that takes it
	task automatic send_beat(input logic k, input data_t d, input word_t c);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		data_in <= d;
		codeword_in <= c;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(codec_predict(k, d, c));
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_encode_directed();
		send_beat(KIND_ENC, '0, '0);
		send_beat(KIND_ENC, '1, '1);
		send_beat(KIND_ENC, 30'h1555_5555, rand_word());
		send_beat(KIND_ENC, 30'h2AAA_AAAA, rand_word());
		send_beat(KIND_ENC, 30'h2000_0000, '0);
		send_beat(KIND_ENC, 30'h0000_0001, '1);
	endtask

	task automatic test_decode_directed();
		word_t base;
		base = encode_word(30'h2AAA_AAAA);
		send_beat(KIND_DEC, '0, base);
		send_beat(KIND_DEC, '1, flip_at(base, 13));
		send_beat(KIND_DEC, '0, flip_at(base, 32));
		send_beat(KIND_DEC, '0, flip_at(base, 39));
		// lone overall parity flip: zero syndrome, reported clean
		send_beat(KIND_DEC, '0, flip_at(base, 0));
		send_beat(KIND_DEC, '0, flip_at(flip_at(base, 9), 21));
		// reserved bits set on a clean word are dropped
		send_beat(KIND_DEC, '0, base | ~RESERVED_CLEAR);
		// syndrome points at a reserved position: it gets set
		send_beat(KIND_DEC, '0, flip_at(flip_at(flip_at(base, 0), 1), 2));
		send_beat(KIND_DEC, '0, flip_at(flip_at(flip_at(base, 0), 2), 4));
		// syndrome past the word: corrected status, nothing flipped
		send_beat(KIND_DEC, '0, flip_at(flip_at(flip_at(base, 0), 8), 32));
		send_beat(KIND_DEC, '0, flip_at(flip_at(flip_at(base, 0), 31), 32));
		send_beat(KIND_DEC, '1, '0);
		send_beat(KIND_DEC, '0, '1);
	endtask

	task automatic test_random_mix(input int count);
		data_t d;
		word_t c;
		int p;
		int q;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				steady_flow = ($urandom_range(0, 3) == 0);
			end
			d = rand_data();
			c = rand_word();
			if ($urandom_range(0, 9) < 3) begin
				send_beat(KIND_ENC, d, c);
			end else begin
				c = encode_word(rand_data());
				case ($urandom_range(0, 5))
					1, 2: begin
						c = flip_at(c, $urandom_range(0, 39));
					end
					3: begin
						p = $urandom_range(0, 39);
						q = (p + $urandom_range(1, 39)) % WORD_W;
						c = flip_at(flip_at(c, p), q);
					end
					4: begin
						repeat ($urandom_range(3, 6)) c = flip_at(c, $urandom_range(0, 39));
					end
					5: begin
						c = rand_word();
					end
					default: begin
					end
				endcase
				if ($urandom_range(0, 3) == 0) begin
					c |= ~RESERVED_CLEAR & rand_word();
				end
				send_beat(KIND_DEC, d, c);
			end
		end
	endtask

	always @(posedge clk) begin
		codec_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", codeword_out, '0);
			end else begin
				want = pending_results.pop_front();
				if (codeword_out !== want.cw) begin
					report_mismatch("codeword_out", codeword_out, want.cw);
				end
				if (data_out !== want.data) begin
					report_mismatch("data_out", 40'(data_out), 40'(want.data));
				end
				if (status !== want.st) begin
					report_mismatch("status", 40'(status), 40'(want.st));
				end
			end
		end
	end

	// counts cycles with no beat moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		kind <= KIND_ENC;
		data_in <= '0;
		codeword_in <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encode_directed();
		test_decode_directed();
		wait_for_results();
		test_random_mix(700);
		wait_for_results();
		test_random_mix(700);
		wait_for_results();
		if (mismatch_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/shc_pkg.sv
hdl/shc_enc.sv
hdl/shc_dec.sv
hdl/secded_hamming_codec_30bit_core.sv
verif/testbench.sv
